>>> hdl/matrix4_transform_composer_assert.svh
// Assertion macros used by the checker file.
`ifndef MATRIX4_TRANSFORM_COMPOSER_ASSERT_SVH
`define MATRIX4_TRANSFORM_COMPOSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MTC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define MTC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/mtc_pkg.sv
`default_nettype none
package mtc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] MODE_DIAG  = 3'd0;
    localparam logic [2:0] MODE_LOAD  = 3'd1;
    localparam logic [2:0] MODE_MUL   = 3'd2;
    localparam logic [2:0] MODE_TRANS = 3'd3;
    localparam logic [2:0] MODE_SCALE = 3'd4;
    localparam logic [2:0] MODE_READ  = 3'd5;

    typedef struct packed {
        logic [2:0]         mode;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] val_a;
        logic signed [31:0] val_b;
        logic signed [31:0] val_c;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] element;
        logic               saturated;
    } out_beat_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       issue;
        logic [3:0] idx;
        logic       commit;
        logic       result;
    } mtc_cmd_t;

endpackage
`default_nettype wire

>>> hdl/mtc_datapath.sv
`default_nettype none
module mtc_datapath
    import mtc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  in_beat_t  in_data,
    input  mtc_cmd_t  cmd,
    output out_beat_t out_data
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam int SW = PW + 2;
    localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE  = (FRAC_BITS <= W - 2) ? (W'(1) << FRAC_BITS) : MAXW;
    localparam logic signed [63:0] WMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] WMIN = -(64'sd1 <<< (W - 1));

    // Clamp a 32-bit input into the word range
    function automatic logic [W-1:0] to_word(input logic signed [31:0] raw);
        logic signed [63:0] v;
        v = 64'(raw);
        if (v > WMAX)
            return MAXW;
        else if (v < WMIN)
            return MINW;
        else
            return W'(v);
    endfunction

    logic [W-1:0] cur_reg [16];
    logic [W-1:0] op_reg  [16];
    logic [W-1:0] new_reg [16];
    logic [W-1:0] a_reg, b_reg, c_reg;
    logic [2:0]   mode_reg;
    logic [1:0]   row_reg, col_reg;
    logic signed [PW-1:0] prod_reg [4];
    logic         v1_reg;
    logic [3:0]   idx1_reg;
    logic         clip_reg;
    out_beat_t    out_reg;

    logic [W-1:0] opv  [4];
    logic [W-1:0] oldv [4];
    logic [1:0]   ii, jj;
    logic signed [SW-1:0] sum, sh;
    logic [W-1:0] sat_val;
    logic         sat_clip;

    assign ii = cmd.idx[3:2];
    assign jj = cmd.idx[1:0];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            oldv[k] = cur_reg[{2'(k), jj}];
            opv[k]  = '0;
            case (mode_reg)
                MODE_MUL:
                    opv[k] = op_reg[{ii, 2'(k)}];
                MODE_TRANS:
                    if (ii == 2'd3 && k == 0)
                        opv[k] = a_reg;
                    else if (ii == 2'd3 && k == 1)
                        opv[k] = b_reg;
                    else if (ii == 2'd3 && k == 2)
                        opv[k] = c_reg;
                    else if (ii == 2'(k))
                        opv[k] = ONE;
                MODE_SCALE:
                    if (ii == 2'(k))
                    begin
                        if (k == 0)
                            opv[k] = a_reg;
                        else if (k == 1)
                            opv[k] = b_reg;
                        else if (k == 2)
                            opv[k] = c_reg;
                        else
                            opv[k] = ONE;
                    end
                default:
                    opv[k] = '0;
            endcase
        end
    end

    // Sum, shift and saturate the four products
    always_comb
    begin
        sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2]) + SW'(prod_reg[3]);
        sh  = sum >>> FRAC_BITS;
        if (sh[SW-1:W-1] == '0 || sh[SW-1:W-1] == '1)
        begin
            sat_val  = sh[W-1:0];
            sat_clip = 1'b0;
        end
        else
        begin
            sat_val  = sh[SW-1] ? MINW : MAXW;
            sat_clip = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < 16; e++)
            begin
                cur_reg[e] <= (e % 5 == 0) ? ONE : '0;
                op_reg[e]  <= '0;
            end
            v1_reg   <= 1'b0;
            clip_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            if (cmd.load)
            begin
                clip_reg <= 1'b0;
                if (in_data.mode == MODE_DIAG)
                    for (int e = 0; e < 16; e++)
                        cur_reg[e] <= (e % 5 == 0) ? to_word(in_data.val_a) : '0;
                if (in_data.mode == MODE_LOAD)
                    op_reg[{in_data.row, in_data.col}] <= to_word(in_data.val_a);
            end
            else if (v1_reg && sat_clip)
                clip_reg <= 1'b1;
            if (cmd.commit)
                for (int e = 0; e < 16; e++)
                    cur_reg[e] <= new_reg[e];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data.mode;
            row_reg  <= in_data.row;
            col_reg  <= in_data.col;
            a_reg    <= to_word(in_data.val_a);
            b_reg    <= to_word(in_data.val_b);
            c_reg    <= to_word(in_data.val_c);
        end
        if (cmd.issue)
        begin
            for (int k = 0; k < 4; k++)
                prod_reg[k] <= PW'(signed'(oldv[k])) * PW'(signed'(opv[k]));
            idx1_reg <= cmd.idx;
        end
        if (v1_reg)
            new_reg[idx1_reg] <= sat_val;
        if (cmd.result)
        begin
            out_reg.element   <= 32'(signed'(cur_reg[{row_reg, col_reg}]));
            out_reg.saturated <= clip_reg;
        end
    end

    assign out_data = out_reg;

endmodule
`default_nettype wire

>>> hdl/mtc_controller.sv
`default_nettype none
module mtc_controller
    import mtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [2:0] in_mode,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    output mtc_cmd_t        cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       is_compose, can_load;

    assign is_compose = (in_mode == MODE_MUL) || (in_mode == MODE_TRANS)
                        || (in_mode == MODE_SCALE);
    assign can_load   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.idx        = cnt_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = is_compose ? S_MUL : S_RESULT;
                end
            S_MUL:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_COMMIT;
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
                if (can_load)
                begin
                    cmd.result     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> hdl/matrix4_transform_composer.sv
`default_nettype none
// 4x4 transform composer in signed fixed point (Q16.16 by default). Each input
// beat runs one action: load a scaled identity, write one operand element,
// compose the current matrix with the operand, a translation or a scale, or
// just read; every beat returns one output beat holding the current element
// (row, col) and a flag set if any element clipped during the compose.
// A compose beat runs from acceptance to the result register as follows: four
// multipliers work through the 16 elements one per cycle, then the drain,
// commit and result states follow; other beats go straight to the result
// state. The input is stalled until the result is written. One beat is in
// work at a time; a finished result waits in the output register while the
// next input beat is taken. Input values are clamped to the word width.
module matrix4_transform_composer
    import mtc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  wire logic out_stall,
    output out_beat_t out_data
);

    mtc_cmd_t cmd;

    // Sequence the element sweep and the output handshake
    mtc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (in_data.mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Hold the current, operand and new matrices, the multipliers and the result register
    mtc_datapath #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .out_data (out_data)
    );

endmodule
`default_nettype wire

>>> hdl/mtc_checker.sv
`default_nettype none
`include "matrix4_transform_composer_assert.svh"
module mtc_checker
    import mtc_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input in_beat_t  in_data,
    input wire logic out_valid,
    input wire logic out_stall,
    input out_beat_t out_data
);

    logic in_acc, comp_acc;

    assign in_acc   = in_valid && !in_stall;
    assign comp_acc = in_acc && (in_data.mode == MODE_MUL || in_data.mode == MODE_TRANS
                                 || in_data.mode == MODE_SCALE);

    `MTC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    `MTC_ASSERT_NXT(a_busy_after, in_acc, in_stall)
    `MTC_ASSERT_IMP(a_compose_busy, comp_acc, ##12 in_stall)

endmodule

bind matrix4_transform_composer mtc_checker u_mtc_checker (.*);
`default_nettype wire

>>> verif/matrix4_transform_composer_tb.sv
`default_nettype none
module matrix4_transform_composer_tb;
    import mtc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_beat_t in_data;
    logic out_valid;
    logic out_stall;
    out_beat_t out_data;

    matrix4_transform_composer dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    // Shadow copies of the block's two matrices, index row*4+col
    logic signed [31:0] cur_mat [16];
    logic signed [31:0] opnd_mat [16];

    in_beat_t pending_beats [$];
    out_beat_t expected_elements [$];

    int idle_pct;       // sender idle percentage for the current phase
    int stall_pct;      // receiver stall percentage for the current phase
    int hold_off;       // cycles of forced receiver stall still to run
    int mismatches;
    int quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Compose the shadow current matrix with m: new[i][j] = sum_k old[k][j]*m[i][k].
    // Sum at full width, arithmetic shift, clip to the 32-bit word.
    function automatic bit compose_with(input logic signed [31:0] m [16]);
        logic signed [31:0] prev [16];
        logic signed [95:0] acc;
        logic signed [95:0] shifted;
        bit clipped;
        clipped = 1'b0;
        prev = cur_mat;
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                acc = '0;
                for (int k = 0; k < 4; k++)
                    acc += 96'(prev[k*4+j]) * 96'(m[i*4+k]);
                shifted = acc >>> FRAC;
                if (shifted > 96'(WORD_MAX))
                begin
                    cur_mat[i*4+j] = WORD_MAX;
                    clipped = 1'b1;
                end
                else if (shifted < 96'(WORD_MIN))
                begin
                    cur_mat[i*4+j] = WORD_MIN;
                    clipped = 1'b1;
                end
                else
                    cur_mat[i*4+j] = shifted[31:0];
            end
        end
        return clipped;
    endfunction

    // Apply one beat to the shadow state and return the element it reads back
    function automatic out_beat_t apply_beat(input in_beat_t b);
        logic signed [31:0] m [16];
        out_beat_t r;
        bit clipped;
        clipped = 1'b0;
        foreach (m[n])
            m[n] = (n % 5 == 0) ? ONE_Q : '0;
        case (b.mode)
            MODE_DIAG:
                foreach (cur_mat[n])
                    cur_mat[n] = (n % 5 == 0) ? b.val_a : '0;
            MODE_LOAD:
                opnd_mat[{b.row, b.col}] = b.val_a;
            MODE_MUL:
                clipped = compose_with(opnd_mat);
            MODE_TRANS:
            begin
                m[12] = b.val_a;
                m[13] = b.val_b;
                m[14] = b.val_c;
                clipped = compose_with(m);
            end
            MODE_SCALE:
            begin
                m[0] = b.val_a;
                m[5] = b.val_b;
                m[10] = b.val_c;
                clipped = compose_with(m);
            end
            default: ;
        endcase
        r.element = cur_mat[{b.row, b.col}];
        r.saturated = clipped;
        return r;
    endfunction

    function automatic logic signed [31:0] random_word(input int flavour);
        case (flavour)
            0: return $urandom();
            1: return WORD_MAX;
            2: return WORD_MIN;
            3: return ONE_Q;
            4: return -ONE_Q;
            5: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            default: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
        endcase
    endfunction

    function automatic in_beat_t make_beat(input logic [2:0] mode, input logic [1:0] row,
                                           input logic [1:0] col, input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic signed [31:0] c);
        in_beat_t x;
        x.mode = mode;
        x.row = row;
        x.col = col;
        x.val_a = a;
        x.val_b = b;
        x.val_c = c;
        return x;
    endfunction

    // Random beat: val_a mostly moderate with the odd extreme value, val_b and
    // val_c drawn from every flavour, extremes included, to reach the clipping paths
    function automatic in_beat_t random_beat();
        int pick;
        int flav;
        logic [2:0] mode;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            mode = MODE_DIAG;
        else if (pick < 40)
            mode = MODE_LOAD;
        else if (pick < 55)
            mode = MODE_MUL;
        else if (pick < 70)
            mode = MODE_TRANS;
        else if (pick < 85)
            mode = MODE_SCALE;
        else if (pick < 95)
            mode = MODE_READ;
        else
            mode = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
        flav = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 6);
        return make_beat(mode, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         random_word(flav), random_word($urandom_range(0, 6)),
                         random_word($urandom_range(0, 6)));
    endfunction

    // Driver: advance to the next pending beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_beats.size() > 0 && $urandom_range(1, 100) > idle_pct)
            begin
                in_valid <= 1'b1;
                in_data <= pending_beats.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with a long forced hold-off when asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_off > 0)
        begin
            out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end
        else
            out_stall <= ($urandom_range(1, 100) <= stall_pct);
    end

    // Predict at input acceptance, check at output acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_elements.push_back(apply_beat(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_elements.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output beat: element %0d sat %0b",
                                 out_data.element, out_data.saturated);
                end
                else
                begin
                    out_beat_t want;
                    want = expected_elements.pop_front();
                    if (want.element !== out_data.element ||
                        want.saturated !== out_data.saturated)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: element exp %0d got %0d, sat exp %0b got %0b",
                                     want.element, out_data.element,
                                     want.saturated, out_data.saturated);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[matrix4_transform_composer] ERROR");
            $finish;
        end
    end

    task automatic drain_all();
        while (pending_beats.size() > 0 || in_valid || expected_elements.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        repeat (count)
            pending_beats.push_back(random_beat());
        drain_all();
    endtask

    initial
    begin
        mismatches = 0;
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        foreach (cur_mat[n])
        begin
            cur_mat[n] = (n % 5 == 0) ? ONE_Q : '0;
            opnd_mat[n] = '0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: read reset state, multiply by the empty operand, every mode,
        // extremes and clipping in both directions
        pending_beats.push_back(make_beat(MODE_READ, 2'd0, 2'd0, '0, '0, '0));
        pending_beats.push_back(make_beat(MODE_READ, 2'd3, 2'd3, '0, '0, '0));
        pending_beats.push_back(make_beat(MODE_MUL, 2'd1, 2'd1, '0, '0, '0));
        pending_beats.push_back(make_beat(MODE_DIAG, 2'd2, 2'd2, ONE_Q, '0, '0));
        pending_beats.push_back(make_beat(MODE_TRANS, 2'd3, 2'd0, 32'sh0003_8000,
                                          -32'sh0002_0000, '0));
        pending_beats.push_back(make_beat(MODE_TRANS, 2'd3, 2'd2, 32'sh0001_0000,
                                          32'sh0001_0000, 32'sh0005_0000));
        pending_beats.push_back(make_beat(MODE_SCALE, 2'd0, 2'd0, 32'sh0002_0000,
                                          -32'sh0000_8000, 32'sh0000_0001));
        pending_beats.push_back(make_beat(MODE_LOAD, 2'd3, 2'd3, WORD_MAX, '0, '0));
        pending_beats.push_back(make_beat(MODE_LOAD, 2'd0, 2'd0, WORD_MIN, '0, '0));
        pending_beats.push_back(make_beat(MODE_LOAD, 2'd1, 2'd2, -32'sh0000_0001, '0, '0));
        pending_beats.push_back(make_beat(MODE_MUL, 2'd0, 2'd0, '0, '0, '0));
        pending_beats.push_back(make_beat(MODE_DIAG, 2'd1, 2'd1, WORD_MAX, '0, '0));
        pending_beats.push_back(make_beat(MODE_SCALE, 2'd1, 2'd1, WORD_MAX, WORD_MAX,
                                          WORD_MAX));
        pending_beats.push_back(make_beat(MODE_DIAG, 2'd0, 2'd0, WORD_MIN, '0, '0));
        pending_beats.push_back(make_beat(MODE_SCALE, 2'd2, 2'd2, WORD_MIN, WORD_MIN,
                                          WORD_MAX));
        pending_beats.push_back(make_beat(MODE_TRANS, 2'd3, 2'd1, WORD_MIN, WORD_MAX,
                                          WORD_MIN));
        pending_beats.push_back(make_beat(MODE_SPARE6, 2'd3, 2'd1, 32'shffff_ffff,
                                          32'shffff_ffff, 32'shffff_ffff));
        pending_beats.push_back(make_beat(MODE_SPARE7, 2'd2, 2'd3, '0, '0, '0));
        pending_beats.push_back(make_beat(MODE_DIAG, 2'd0, 2'd3, -32'sh0000_0001, '0, '0));
        pending_beats.push_back(make_beat(MODE_READ, 2'd3, 2'd3, '0, '0, '0));
        drain_all();

        // Random phases with different idle and stall mixes
        run_random(400, 0, 0);
        run_random(350, 50, 0);
        run_random(350, 0, 50);
        run_random(300, 11, 11);

        // Back-pressure: hold the receiver off while the sender keeps offering
        idle_pct = 0;
        stall_pct = 0;
        hold_off = 300;
        run_random(100, 0, 0);

        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_elements.size() == 0)
            $display("[matrix4_transform_composer] OK");
        else
            $display("[matrix4_transform_composer] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
